@@ hdl/aescbc_pkg.sv @@
// ----------------------------------------------------------------------------
// aescbc_pkg
// shared constants, types and byte functions of the aes cbc encryption unit
// ----------------------------------------------------------------------------
package aescbc_pkg;

	localparam int KEY_WORDS = 4;
	localparam int ROUNDS    = KEY_WORDS + 6;
	localparam int RK_WORDS  = 4 * (ROUNDS + 1);
	localparam int RK_AW     = $clog2(RK_WORDS);
	localparam int RND_W     = $clog2(ROUNDS + 1);

	localparam logic [2:0] REG_KEY_0   = 3'd0;
	localparam logic [2:0] REG_KEY_1   = 3'd1;
	localparam logic [2:0] REG_KEY_2   = 3'd2;
	localparam logic [2:0] REG_KEY_3   = 3'd3;
	localparam logic [2:0] REG_IV_HIGH = 3'd4;
	localparam logic [2:0] REG_IV_LOW  = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEY_RD,
		ST_KEY_WR,
		ST_LOAD,
		ST_ROUND,
		ST_DONE
	} state_t;

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
		};
		return t[x];
	endfunction

	function automatic logic [7:0] rcon(input logic [3:0] i);
		logic [7:0] t [16];
		t = '{8'h8d,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,
		      8'h80,8'h1b,8'h36,8'h6c,8'hd8,8'hab,8'h4d,8'h9a};
		return t[i];
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

endpackage

@@ hdl/aescbc_round.sv @@
// ----------------------------------------------------------------------------
// aescbc_round
// one aes encryption round: sub bytes, shift rows, optional mix columns, key add
// ----------------------------------------------------------------------------
module aescbc_round import aescbc_pkg::*; (
	input  logic [127:0] state_in,
	input  logic [127:0] round_key,
	input  logic         last,
	output logic [127:0] state_out
);

	logic [7:0] b [16];
	logic [7:0] s [16];
	logic [7:0] m [16];

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			b[i] = state_in[127 - 8 * i -: 8];
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				s[4 * c + r] = sbox(b[4 * ((c + r) % 4) + r]);
			end
		end
		for (int c = 0; c < 4; c++) begin
			logic [7:0] all;
			all = s[4*c] ^ s[4*c+1] ^ s[4*c+2] ^ s[4*c+3];
			m[4*c]   = s[4*c]   ^ all ^ xtime(s[4*c]   ^ s[4*c+1]);
			m[4*c+1] = s[4*c+1] ^ all ^ xtime(s[4*c+1] ^ s[4*c+2]);
			m[4*c+2] = s[4*c+2] ^ all ^ xtime(s[4*c+2] ^ s[4*c+3]);
			m[4*c+3] = s[4*c+3] ^ all ^ xtime(s[4*c+3] ^ s[4*c]);
		end
		for (int i = 0; i < 16; i++) begin
			state_out[127 - 8 * i -: 8] = (last ? s[i] : m[i]) ^ round_key[127 - 8 * i -: 8];
		end
	end

endmodule

@@ hdl/aes_cbc_encrypt_unit.sv @@
// ----------------------------------------------------------------------------
// aes_cbc_encrypt_unit
// aes cbc encryption of 128-bit words with round keys held in memory
// ----------------------------------------------------------------------------
// usage
//  - input channel: data_high/data_low with in_valid/in_stall; a word is taken
//    when in_valid is high and in_stall low
//  - output channel: cipher_high/cipher_low with out_valid/out_stall
//  - config: cfg_we, cfg_index, cfg_data; key parts 0..3, iv halves 4 and 5
//  - the round keys live in a one-port-read memory of 4*(rounds+1) words of 32
//    bits; a round reads its four key words back to back, the next address
//    issued while the previous word comes out
//  - with the keys ready, a taken word passes through the load, round and done
//    states before its result shows, the rounds paced by the single read port
//    of the key memory; the next word is taken only once the unit is idle
//    again, and blocks go one at a time, since the ciphertext is the next
//    chain value
//  - after reset or a key write, the first word first runs the key expansion:
//    the key is copied, then each further key word is made by reading w[i-nk]
//    and writing w[i]
//  - the result sits in an output register; the next word is taken only after
//    the result has left, and a stall simply holds it
//  - reset clears the chain value, key registers and key-ready flag
// ----------------------------------------------------------------------------
module aes_cbc_encrypt_unit import aescbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] data_high,
	input  logic [63:0] data_low,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] cipher_high,
	output logic [63:0] cipher_low
);

	// round key memory
	logic [31:0] rk_mem [RK_WORDS];
	logic [31:0] rk_rd_q;
	logic [RK_AW-1:0] rd_addr;
	logic        wr_en;
	logic [31:0] wr_data;

	state_t      state_q, state_d;
	logic [63:0] key_q [4];
	logic [127:0] chain_q;
	logic        keys_ready_q;
	logic [127:0] blk_q;
	logic [127:0] out_q;
	logic        out_valid_q;
	logic [RK_AW-1:0] idx_q;       // key word index being expanded
	logic        phase_q;          // expansion: 0 reads w[i-nk], 1 writes w[i]
	logic [31:0] prev_q;           // w[i-1] during expansion
	logic [2:0]  kmod_q;           // i mod nk
	logic [3:0]  kdiv_q;           // i / nk, the rcon index
	logic [1:0]  col_q;            // column of the round key coming out of memory
	logic [RND_W-1:0] rnd_q;       // round being gathered
	logic [95:0] rk_acc_q;         // first three columns of the round key
	logic [127:0] rnd_out;
	logic [127:0] rk_full;
	logic        last_rnd;
	logic [31:0] t_word;
	logic [31:0] key_word;

	// memory written at one port, read at one port with registered data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			rk_mem[idx_q] <= wr_data;
		end
		rk_rd_q <= rk_mem[rd_addr];
	end

	assign in_stall  = (state_q != ST_IDLE) || out_valid_q;
	assign out_valid = out_valid_q;
	assign cipher_high = out_q[127:64];
	assign cipher_low  = out_q[63:0];

	assign rk_full  = {rk_acc_q, rk_rd_q};
	assign last_rnd = (rnd_q == RND_W'(ROUNDS));

	aescbc_round u_round (
		.state_in  (blk_q),
		.round_key (rk_full),
		.last      (last_rnd),
		.state_out (rnd_out)
	);

	// initial key words come straight from the key registers
	always_comb begin
		logic [63:0] p;
		p = key_q[idx_q[2:1]];
		key_word = idx_q[0] ? p[31:0] : p[63:32];
	end

	// key schedule word, prev_q is w[i-1] and rk_rd_q is w[i-nk]
	always_comb begin
		t_word = prev_q;
		if (kmod_q == '0) begin
			t_word = sub_word({prev_q[23:0], prev_q[31:24]}) ^ {rcon(kdiv_q), 24'h0};
		end else if (KEY_WORDS > 6 && kmod_q == 3'd4) begin
			t_word = sub_word(prev_q);
		end
		wr_data = (state_q == ST_KEY_RD) ? key_word : (rk_rd_q ^ t_word);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && !in_stall) begin
					state_d = keys_ready_q ? ST_LOAD : ST_KEY_RD;
				end
			end
			ST_KEY_RD: begin
				if (idx_q == RK_AW'(KEY_WORDS - 1)) begin
					state_d = ST_KEY_WR;
				end
			end
			ST_KEY_WR: begin
				if (phase_q && idx_q == RK_AW'(RK_WORDS - 1)) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD:  state_d = ST_ROUND;
			ST_ROUND: begin
				if (col_q == 2'd3 && last_rnd) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		wr_en   = 1'b0;
		rd_addr = '0;
		unique case (state_q)
			ST_KEY_RD: begin
				wr_en = 1'b1;
			end
			ST_KEY_WR: begin
				rd_addr = idx_q - RK_AW'(KEY_WORDS);
				wr_en   = phase_q;
			end
			ST_LOAD: begin
				rd_addr = '0;
			end
			ST_ROUND: begin
				// address one ahead of the word coming out, none past the end
				rd_addr = (col_q == 2'd3 && last_rnd) ? '0 :
				          RK_AW'({rnd_q, col_q}) + RK_AW'(1);
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			keys_ready_q <= 1'b0;
			chain_q      <= '0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
			idx_q        <= '0;
			phase_q      <= 1'b0;
			prev_q       <= '0;
			kmod_q       <= '0;
			kdiv_q       <= '0;
			col_q        <= '0;
			rnd_q        <= '0;
			rk_acc_q     <= '0;
			blk_q        <= '0;
			out_q        <= '0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_KEY_0, REG_KEY_1, REG_KEY_2, REG_KEY_3: begin
						key_q[cfg_index[1:0]] <= cfg_data;
						keys_ready_q <= 1'b0;
					end
					REG_IV_HIGH: chain_q[127:64] <= cfg_data;
					REG_IV_LOW:  chain_q[63:0]   <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					idx_q   <= '0;
					phase_q <= 1'b0;
					if (in_valid && !in_stall) begin
						blk_q <= {data_high, data_low} ^ chain_q;
					end
				end
				ST_KEY_RD: begin
					idx_q  <= idx_q + RK_AW'(1);
					prev_q <= key_word;
					kmod_q <= '0;
					kdiv_q <= 4'd1;
				end
				ST_KEY_WR: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						// the word just written is w[i-1] of the next one
						prev_q <= wr_data;
						idx_q  <= idx_q + RK_AW'(1);
						if (kmod_q == 3'(KEY_WORDS - 1)) begin
							kmod_q <= '0;
							kdiv_q <= kdiv_q + 4'd1;
						end else begin
							kmod_q <= kmod_q + 3'd1;
						end
					end
					if (phase_q && idx_q == RK_AW'(RK_WORDS - 1)) keys_ready_q <= 1'b1;
				end
				ST_LOAD: begin
					col_q <= 2'd0;
					rnd_q <= '0;
				end
				ST_ROUND: begin
					rk_acc_q <= {rk_acc_q[63:0], rk_rd_q};
					if (col_q == 2'd3) begin
						// all four columns in: apply round (round 0 is key add)
						if (rnd_q == '0) blk_q <= blk_q ^ rk_full;
						else             blk_q <= rnd_out;
						rnd_q <= rnd_q + RND_W'(1);
					end
					col_q <= col_q + 2'd1;
				end
				ST_DONE: begin
					out_q       <= blk_q;
					chain_q     <= blk_q;
					out_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

endmodule

@@ hdl/aescbc_checker.sv @@
// ----------------------------------------------------------------------------
// aescbc_checker
// port-level checks of the aes cbc encryption unit
// ----------------------------------------------------------------------------
module aescbc_checker import aescbc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] cipher_high,
	input logic [63:0] cipher_low
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cipher_high) && $stable(cipher_low))
		else $error("stalled result changed");

	// no word taken while a result waits
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");

	// a word taken cannot produce a result at once
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !out_valid)
		else $error("result too early");

endmodule

bind aes_cbc_encrypt_unit aescbc_checker u_checker (.*);
